// ----- sv/cabb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabb_pkg: shared definitions for the command-addressed byte buffer
// Widths, codes, register indexes and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cabb_pkg;

   // Store geometry
   localparam int DEPTH  = 128;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ADDR_W = 8;
   localparam int DATA_W = 8;
   localparam int ID_W   = 5;

   // Configuration port
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_ID = CSR_IDX_W'(1);
   localparam logic [ID_W-1:0]      OWN_ID_RESET   = ID_W'(4);
   localparam logic [ID_W-1:0]      REPLY_ID_RESET = ID_W'(0);

   // Mode bytes and interrupt code
   localparam logic [DATA_W-1:0] MODE_RD  = DATA_W'(0);
   localparam logic [DATA_W-1:0] MODE_WR  = DATA_W'(1);
   localparam logic [DATA_W-1:0] INT_CODE = DATA_W'(33);

   // Commands from controller to datapath
   typedef struct packed {
      logic latch_mode;   // capture mode byte
      logic latch_addr;   // capture address byte
      logic write_en;     // store data byte at captured address
      logic read_en;      // read store at incoming address byte
      logic load_reply;   // load data reply into the response register
      logic load_intr;    // load interrupt message into the response register
      logic clear_map;    // drop every valid bit
   } cabb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic addressed;    // request destination matches own id
      logic mode_rd;      // captured mode is read
      logic mode_wr;      // captured mode is write
      logic read_intr;    // last read hit the top entry or returned zero
   } cabb_status_type;

endpackage

// ----- sv/command_addressed_byte_buffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_addressed_byte_buffer_top: byte buffer device on a message bus
// Responds to requests for its own id: mode, address and data bytes drive
// reads and writes of a small byte store; reads reply to the reply id.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | halt_flag, dest_id, payload
//  rsp     | out       | rsp_valid/stall    | out_interrupt, out_dest_id,
//          |           |                    | out_payload, last
//  csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// A request with no reply is taken without a stall. A read first does the
// registered store access, then loads the response register, then presents
// one or two replies, each held while rsp_stall is high; req_stall stays high
// until the last reply is taken. Reset clears the phase, halt state and the
// whole valid map at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module command_addressed_byte_buffer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_halt_flag,
   input  logic [cabb_pkg::ID_W-1:0]      req_dest_id,
   input  logic [cabb_pkg::DATA_W-1:0]    req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_out_interrupt,
   output logic [cabb_pkg::ID_W-1:0]      rsp_out_dest_id,
   output logic [cabb_pkg::DATA_W-1:0]    rsp_out_payload,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cabb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cabb_pkg::ID_W-1:0]      csr_data
);

   cabb_pkg::cabb_cmd_type    cmd;
   cabb_pkg::cabb_status_type status;

   // Take configuration writes at any time
   assign csr_ready = 1'b1;

   cabb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_halt_flag (req_halt_flag),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   cabb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_dest_id       (req_dest_id),
      .req_payload       (req_payload),
      .cmd               (cmd),
      .status            (status),
      .rsp_out_interrupt (rsp_out_interrupt),
      .rsp_out_dest_id   (rsp_out_dest_id),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- sv/cabb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabb_ctrl: sequencing controller
// Tracks the mode/address/data phase, the halt state and the response
// handshake, and drives datapath commands.
// ----------------------------------------------------------------------------
module cabb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_halt_flag,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  cabb_pkg::cabb_status_type status,
   output cabb_pkg::cabb_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_REPLY = 4'b0100,
      ST_INTR  = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      PH_MODE = 3'b001,
      PH_ADDR = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      stopped_ff, stopped_in;
   logic      req_take;
   logic      rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_REPLY) || (state_ff == ST_INTR);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Decide next state, phase and datapath commands
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      stopped_in = stopped_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && !stopped_ff && status.addressed) begin
               if (req_halt_flag) begin
                  stopped_in = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_MODE: begin
                        cmd.latch_mode = 1'b1;
                        phase_in       = PH_ADDR;
                     end
                     PH_ADDR: begin
                        cmd.latch_addr = 1'b1;
                        if (status.mode_wr) begin
                           phase_in = PH_DATA;
                        end else if (status.mode_rd) begin
                           cmd.read_en = 1'b1;
                           phase_in    = PH_MODE;
                           state_in    = ST_READ;
                        end
                     end
                     PH_DATA: begin
                        cmd.write_en = 1'b1;
                        phase_in     = PH_MODE;
                     end
                     default: begin
                        phase_in = PH_MODE;
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            cmd.load_reply = 1'b1;
            cmd.clear_map  = status.read_intr;
            state_in       = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_take) begin
               if (status.read_intr) begin
                  cmd.load_intr = 1'b1;
                  state_in      = ST_INTR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_INTR: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_MODE;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ----- sv/cabb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabb_dp: byte buffer datapath
// Configuration registers, mode and address capture, the byte store with its
// valid map, and the response register.
// ----------------------------------------------------------------------------
module cabb_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [cabb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cabb_pkg::ID_W-1:0]         csr_data,
   input  logic [cabb_pkg::ID_W-1:0]         req_dest_id,
   input  logic [cabb_pkg::DATA_W-1:0]       req_payload,
   input  cabb_pkg::cabb_cmd_type            cmd,
   output cabb_pkg::cabb_status_type         status,
   output logic                              rsp_out_interrupt,
   output logic [cabb_pkg::ID_W-1:0]         rsp_out_dest_id,
   output logic [cabb_pkg::DATA_W-1:0]       rsp_out_payload,
   output logic                              rsp_last
);

   logic [cabb_pkg::ID_W-1:0]   own_id_ff;
   logic [cabb_pkg::ID_W-1:0]   reply_id_ff;
   logic [cabb_pkg::DATA_W-1:0] op_mode_ff;
   logic [cabb_pkg::ADDR_W-1:0] cur_address_ff;
   logic [cabb_pkg::DATA_W-1:0] byte_store [cabb_pkg::DEPTH];
   logic [cabb_pkg::DEPTH-1:0]  entry_valid_ff;
   logic [cabb_pkg::DATA_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;
   logic                        rd_top_ff;
   logic [cabb_pkg::DATA_W-1:0] read_byte;
   logic                        wr_in_range;
   logic                        rd_in_range;
   logic [cabb_pkg::IDX_W-1:0]  wr_idx;
   logic [cabb_pkg::IDX_W-1:0]  rd_idx;

   assign wr_idx      = cur_address_ff[cabb_pkg::IDX_W-1:0];
   assign rd_idx      = req_payload[cabb_pkg::IDX_W-1:0];
   assign wr_in_range = ({1'b0, cur_address_ff} < (cabb_pkg::ADDR_W+1)'(cabb_pkg::DEPTH));
   assign rd_in_range = ({1'b0, req_payload} < (cabb_pkg::ADDR_W+1)'(cabb_pkg::DEPTH));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff   <= cabb_pkg::OWN_ID_RESET;
         reply_id_ff <= cabb_pkg::REPLY_ID_RESET;
      end else if (csr_valid) begin
         if (csr_index == cabb_pkg::CSR_OWN_ID) begin
            own_id_ff <= csr_data;
         end else if (csr_index == cabb_pkg::CSR_REPLY_ID) begin
            reply_id_ff <= csr_data;
         end
      end
   end

   // Capture mode and address bytes
   always_ff @(posedge clock) begin
      if (cmd.latch_mode) begin
         op_mode_ff <= req_payload;
      end
      if (cmd.latch_addr) begin
         cur_address_ff <= req_payload;
      end
   end

   // Byte store: write at captured address, registered read at request byte
   always_ff @(posedge clock) begin
      if (cmd.write_en && wr_in_range) begin
         byte_store[wr_idx] <= req_payload;
      end
      if (cmd.read_en) begin
         rd_data_ff <= byte_store[rd_idx];
      end
   end

   // Valid map and read qualifiers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (cmd.clear_map) begin
         entry_valid_ff <= '0;
      end else if (cmd.write_en && wr_in_range) begin
         entry_valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_valid_ff <= rd_in_range && entry_valid_ff[rd_idx];
         rd_top_ff   <= ({1'b0, req_payload} == (cabb_pkg::ADDR_W+1)'(cabb_pkg::DEPTH - 1));
      end
   end

   assign read_byte = rd_valid_ff ? rd_data_ff : '0;

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_reply) begin
         rsp_out_interrupt <= 1'b0;
         rsp_out_dest_id   <= reply_id_ff;
         rsp_out_payload   <= read_byte;
         rsp_last          <= !status.read_intr;
      end else if (cmd.load_intr) begin
         rsp_out_interrupt <= 1'b1;
         rsp_out_dest_id   <= reply_id_ff;
         rsp_out_payload   <= cabb_pkg::INT_CODE;
         rsp_last          <= 1'b1;
      end
   end

   // Status toward the controller
   always_comb begin
      status.addressed = (req_dest_id == own_id_ff);
      status.mode_rd   = (op_mode_ff == cabb_pkg::MODE_RD);
      status.mode_wr   = (op_mode_ff == cabb_pkg::MODE_WR);
      status.read_intr = rd_top_ff || (read_byte == '0);
   end

endmodule
